[rtl/irfe_pkg.sv]
// Shared package for the image rotate and flip engine.
// Holds default sizes, field widths, mode and register codes and the command type.
// Has no dependencies; every other file of the block but irfe_ram imports it.
package irfe_pkg;

    localparam int DEF_MAX_SIDE   = 128;
    localparam int DEF_PIXEL_BITS = 32;

    localparam int PIX_W       = 32;
    localparam int COORD_W     = 7;
    localparam int M_TDATA_W   = 48;
    localparam int CFG_ADDR_W  = 4;
    localparam int CFG_DATA_W  = 32;

    localparam logic [7:0] SIDE_RESET = 8'd128;

    localparam logic [2:0] MODE_ROT180     = 3'd0;
    localparam logic [2:0] MODE_ROT90_CW   = 3'd1;
    localparam logic [2:0] MODE_ROT90_CCW  = 3'd2;
    localparam logic [2:0] MODE_VFLIP      = 3'd3;
    localparam logic [2:0] MODE_HFLIP      = 3'd4;

    localparam logic [1:0] REG_MODE   = 2'd0;
    localparam logic [1:0] REG_WIDTH  = 2'd1;
    localparam logic [1:0] REG_HEIGHT = 2'd2;

    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_PULL  = 1'b1;

    typedef struct packed {
        logic store;
        logic pull;
        logic load;
    } irfe_cmd_t;

endpackage

[rtl/image_rotate_flip_engine.sv]
// Top level of the image rotate and flip engine: register port and stream ports.
// Depends on irfe_pkg, irfe_ctrl and irfe_datapath.
//
// Channel   Signals                          Direction  Contents
// s_*       tvalid tready tdata tuser        in         write pixel or pull request
// m_*       tvalid tready tdata tlast tuser  out        transformed pixel with coordinates
// APB       psel penable pwrite paddr ...    in/out     mode, frame_width, frame_height
//
// A write transaction is taken every cycle while no pull is in the read state; a pull
// issues the frame store's registered read and then loads the output register.
// While a result waits in the output register, a following write is taken and a
// following pull waits in the read state until the output register frees.
// Reset clears the counters, the read position and the frame full flag; the frame
// store itself is not cleared and needs no pass after reset.
module image_rotate_flip_engine
    import irfe_pkg::*;
#(
    parameter int MAX_SIDE   = DEF_MAX_SIDE,
    parameter int PIXEL_BITS = DEF_PIXEL_BITS
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [PIX_W-1:0]      s_tdata,   // [31:0] pixel_in
    input  logic                  s_tuser,   // [0] req_type
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,   // [31:0] pixel_out, [38:32] out_x, [45:39] out_y
    output logic                  m_tlast,
    output logic                  m_tuser,   // [0] status
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready
);

    logic [2:0]         mode_reg;
    logic [7:0]         frame_width_reg;
    logic [7:0]         frame_height_reg;
    logic [1:0]         reg_index;
    logic               cfg_write;
    irfe_cmd_t          cmd;
    logic [PIX_W-1:0]   pixel_out;
    logic [COORD_W-1:0] out_x;
    logic [COORD_W-1:0] out_y;

    assign pready    = 1'b1;
    assign reg_index = paddr[3:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg         <= MODE_ROT180;
            frame_width_reg  <= SIDE_RESET;
            frame_height_reg <= SIDE_RESET;
        end
        else if (cfg_write)
        begin
            case (reg_index)
                REG_MODE:   mode_reg         <= pwdata[2:0];
                REG_WIDTH:  frame_width_reg  <= pwdata[7:0];
                REG_HEIGHT: frame_height_reg <= pwdata[7:0];
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_index)
            REG_MODE:   prdata = CFG_DATA_W'(mode_reg);
            REG_WIDTH:  prdata = CFG_DATA_W'(frame_width_reg);
            REG_HEIGHT: prdata = CFG_DATA_W'(frame_height_reg);
            default:    prdata = '0;
        endcase
    end

    irfe_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tuser  (s_tuser),
        .s_tready (s_tready),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .cmd      (cmd)
    );

    irfe_datapath #(
        .MAX_SIDE   (MAX_SIDE),
        .PIXEL_BITS (PIXEL_BITS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .pixel_in     (s_tdata),
        .mode         (mode_reg),
        .frame_width  (frame_width_reg),
        .frame_height (frame_height_reg),
        .pixel_out    (pixel_out),
        .out_x        (out_x),
        .out_y        (out_y),
        .out_last     (m_tlast),
        .out_status   (m_tuser)
    );

    assign m_tdata = {2'b00, out_y, out_x, pixel_out};

endmodule

[rtl/irfe_ram.sv]
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on nothing; used as the frame store.
module irfe_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16384
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] ram_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            ram_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= ram_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/irfe_ctrl.sv]
// Controller state machine of the image rotate and flip engine.
// Depends on irfe_pkg; drives the datapath through irfe_cmd_t.
module irfe_ctrl
    import irfe_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      s_tvalid,
    input  logic      s_tuser,
    output logic      s_tready,
    input  logic      m_tready,
    output logic      m_tvalid,
    output irfe_cmd_t cmd
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_READ = 1'b1;

    logic state_reg;
    logic state_next;
    logic out_valid_reg;
    logic out_valid_next;
    logic accept;
    logic out_free;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;

    always_comb
    begin
        cmd.store      = accept && (s_tuser == REQ_WRITE);
        cmd.pull       = accept && (s_tuser == REQ_PULL);
        cmd.load       = 1'b0;
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !m_tready;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd.pull)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                if (out_free)
                begin
                    cmd.load       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_tvalid = out_valid_reg;

    a_pull_enters_read: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && s_tuser == REQ_PULL) |=> (state_reg == ST_READ))
        else $error("pull transaction did not start a frame store read");

    a_load_shows_result: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> m_tvalid)
        else $error("result loaded but not presented");

    a_stall_holds_read: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_READ && m_tvalid && !m_tready) |=> (state_reg == ST_READ))
        else $error("read finished while the output slot was still occupied");

endmodule

[rtl/irfe_datapath.sv]
// Datapath of the image rotate and flip engine: counters, address math, frame store
// and output registers. Depends on irfe_pkg and irfe_ram.
module irfe_datapath
    import irfe_pkg::*;
#(
    parameter int MAX_SIDE   = DEF_MAX_SIDE,
    parameter int PIXEL_BITS = DEF_PIXEL_BITS
) (
    input  logic               clk,
    input  logic               rst_n,
    input  irfe_cmd_t          cmd,
    input  logic [PIX_W-1:0]   pixel_in,
    input  logic [2:0]         mode,
    input  logic [7:0]         frame_width,
    input  logic [7:0]         frame_height,
    output logic [PIX_W-1:0]   pixel_out,
    output logic [COORD_W-1:0] out_x,
    output logic [COORD_W-1:0] out_y,
    output logic               out_last,
    output logic               out_status
);

    localparam int STORE_BITS = (PIXEL_BITS < PIX_W) ? PIXEL_BITS : PIX_W;
    localparam int DEPTH      = MAX_SIDE * MAX_SIDE;
    localparam int ADDR_W     = $clog2(DEPTH);
    localparam int CNT_W      = $clog2(DEPTH + 1);
    localparam int SIDE_W     = $clog2(MAX_SIDE + 1);
    localparam int POS_W      = $clog2(MAX_SIDE);

    logic [CNT_W-1:0]      write_count_reg;
    logic                  frame_full_reg;
    logic [POS_W-1:0]      read_x_reg;
    logic [POS_W-1:0]      read_y_reg;

    logic [COORD_W-1:0]    pend_x_reg;
    logic [COORD_W-1:0]    pend_y_reg;
    logic                  pend_last_reg;
    logic                  pend_status_reg;

    logic [PIX_W-1:0]      pixel_out_reg;
    logic [COORD_W-1:0]    out_x_reg;
    logic [COORD_W-1:0]    out_y_reg;
    logic                  out_last_reg;
    logic                  out_status_reg;

    logic [SIDE_W-1:0]     w_side;
    logic [SIDE_W-1:0]     h_side;
    logic [SIDE_W-1:0]     ow;
    logic [SIDE_W-1:0]     oh;
    logic                  swap;
    logic                  wrap;
    logic [POS_W-1:0]      cur_x;
    logic [POS_W-1:0]      cur_y;
    logic [SIDE_W-1:0]     x_inc;
    logic [SIDE_W-1:0]     y_inc;
    logic [SIDE_W-1:0]     sx;
    logic [SIDE_W-1:0]     sy;
    logic [ADDR_W-1:0]     rd_addr;
    logic [CNT_W-1:0]      total;
    logic [CNT_W-1:0]      cnt_base;
    logic [CNT_W-1:0]      cnt_inc;
    logic [POS_W-1:0]      read_x_next;
    logic [POS_W-1:0]      read_y_next;
    logic                  is_last;
    logic [STORE_BITS-1:0] rd_data;

    always_comb
    begin
        if (frame_width == 8'd0)
        begin
            w_side = SIDE_W'(1);
        end
        else if (int'(frame_width) > MAX_SIDE)
        begin
            w_side = SIDE_W'(MAX_SIDE);
        end
        else
        begin
            w_side = SIDE_W'(frame_width);
        end
        if (frame_height == 8'd0)
        begin
            h_side = SIDE_W'(1);
        end
        else if (int'(frame_height) > MAX_SIDE)
        begin
            h_side = SIDE_W'(MAX_SIDE);
        end
        else
        begin
            h_side = SIDE_W'(frame_height);
        end
    end

    assign swap  = (mode == MODE_ROT90_CW) || (mode == MODE_ROT90_CCW);
    assign ow    = swap ? h_side : w_side;
    assign oh    = swap ? w_side : h_side;
    assign wrap  = (SIDE_W'(read_x_reg) >= ow) || (SIDE_W'(read_y_reg) >= oh);
    assign cur_x = wrap ? '0 : read_x_reg;
    assign cur_y = wrap ? '0 : read_y_reg;
    assign x_inc = SIDE_W'(cur_x) + SIDE_W'(1);
    assign y_inc = SIDE_W'(cur_y) + SIDE_W'(1);

    always_comb
    begin
        case (mode)
            MODE_ROT180:
            begin
                sx = w_side - SIDE_W'(1) - SIDE_W'(cur_x);
                sy = h_side - SIDE_W'(1) - SIDE_W'(cur_y);
            end
            MODE_ROT90_CW:
            begin
                sx = SIDE_W'(cur_y);
                sy = h_side - SIDE_W'(1) - SIDE_W'(cur_x);
            end
            MODE_ROT90_CCW:
            begin
                sx = w_side - SIDE_W'(1) - SIDE_W'(cur_y);
                sy = SIDE_W'(cur_x);
            end
            MODE_VFLIP:
            begin
                sx = SIDE_W'(cur_x);
                sy = h_side - SIDE_W'(1) - SIDE_W'(cur_y);
            end
            MODE_HFLIP:
            begin
                sx = w_side - SIDE_W'(1) - SIDE_W'(cur_x);
                sy = SIDE_W'(cur_y);
            end
            default:
            begin
                sx = SIDE_W'(cur_x);
                sy = SIDE_W'(cur_y);
            end
        endcase
    end

    assign rd_addr = ADDR_W'(sy) * ADDR_W'(w_side) + ADDR_W'(sx);
    assign is_last = (x_inc == ow) && (y_inc == oh);

    always_comb
    begin
        if (x_inc < ow)
        begin
            read_x_next = POS_W'(x_inc);
            read_y_next = cur_y;
        end
        else
        begin
            read_x_next = '0;
            read_y_next = (y_inc < oh) ? POS_W'(y_inc) : '0;
        end
    end

    assign total    = CNT_W'(w_side) * CNT_W'(h_side);
    assign cnt_base = frame_full_reg ? '0 : write_count_reg;
    assign cnt_inc  = cnt_base + CNT_W'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            write_count_reg <= '0;
            frame_full_reg  <= 1'b0;
            read_x_reg      <= '0;
            read_y_reg      <= '0;
        end
        else if (cmd.store)
        begin
            write_count_reg <= cnt_inc;
            frame_full_reg  <= (cnt_inc >= total);
            if (frame_full_reg)
            begin
                read_x_reg <= '0;
                read_y_reg <= '0;
            end
        end
        else if (cmd.pull && frame_full_reg)
        begin
            read_x_reg <= read_x_next;
            read_y_reg <= read_y_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.pull)
        begin
            pend_status_reg <= !frame_full_reg;
            pend_x_reg      <= frame_full_reg ? COORD_W'(cur_x) : '0;
            pend_y_reg      <= frame_full_reg ? COORD_W'(cur_y) : '0;
            pend_last_reg   <= frame_full_reg && is_last;
        end
        if (cmd.load)
        begin
            pixel_out_reg  <= pend_status_reg ? '0 : PIX_W'(rd_data);
            out_x_reg      <= pend_x_reg;
            out_y_reg      <= pend_y_reg;
            out_last_reg   <= pend_last_reg;
            out_status_reg <= pend_status_reg;
        end
    end

    irfe_ram #(
        .WIDTH (STORE_BITS),
        .DEPTH (DEPTH)
    ) u_frame_store (
        .clk   (clk),
        .we    (cmd.store),
        .waddr (cnt_base[ADDR_W-1:0]),
        .wdata (pixel_in[STORE_BITS-1:0]),
        .re    (cmd.pull),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    assign pixel_out  = pixel_out_reg;
    assign out_x      = out_x_reg;
    assign out_y      = out_y_reg;
    assign out_last   = out_last_reg;
    assign out_status = out_status_reg;

endmodule

[verif/image_rotate_flip_engine_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for image_rotate_flip_engine: loads frames, pulls the
// reoriented pixels and compares each result with a behavioral frame store model.
// Depends on irfe_pkg and the engine RTL; needs no other files.
module image_rotate_flip_engine_tb;
    import irfe_pkg::*;

    localparam int unsigned STORE_DEPTH  = DEF_MAX_SIDE * DEF_MAX_SIDE;
    localparam int unsigned RANDOM_ITEMS = 1800;
    localparam int unsigned DRAIN_CYCLES = 8;
    localparam int unsigned TAIL_CYCLES  = 16;
    localparam int unsigned HOLD_CYCLES  = 400;
    localparam int unsigned HOLD_PULLS   = 16;
    localparam int unsigned CYCLE_LIMIT  = 1000000;
    localparam int unsigned NUM_ROWS     = 25;
    localparam logic [2:0]  MODE_PASS_TOP = 3'd7;

    typedef struct packed {
        logic [PIX_W-1:0]   pixel;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic               last;
        logic               status;
    } pix_result_t;

    typedef enum logic [1:0] {
        ACT_REG,
        ACT_WRITE,
        ACT_PULL
    } step_kind_t;

    typedef struct packed {
        step_kind_t  kind;
        logic [1:0]  reg_sel;
        logic [31:0] value;
        logic        typed;
        pix_result_t want;
    } step_row_t;

    localparam pix_result_t NOT_READY = '{pixel: '0, x: '0, y: '0, last: 1'b0, status: 1'b1};
    localparam pix_result_t NO_TYPED  = '0;

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [PIX_W-1:0]      s_tdata;     // [31:0] pixel_in
    logic                  s_tuser;     // [0] req_type
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_TDATA_W-1:0]  m_tdata;     // [31:0] pixel_out, [38:32] out_x, [45:39] out_y
    logic                  m_tlast;
    logic                  m_tuser;     // [0] status
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    logic [PIX_W-1:0] image_copy [STORE_DEPTH];
    int unsigned      wr_count;
    int unsigned      rd_x;
    int unsigned      rd_y;
    int unsigned      loaded_span;
    bit               frame_done;
    logic [2:0]       cfg_mode;
    logic [7:0]       cfg_width;
    logic [7:0]       cfg_height;

    pix_result_t pending_pixels [$];
    step_row_t   plan [NUM_ROWS];
    int unsigned items_sent;
    int unsigned fail_cnt;
    int unsigned cycle_cnt;
    bit          burst;
    bit          hold_req;

    image_rotate_flip_engine DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    function automatic int unsigned side_of(input logic [7:0] v);
        if (v == 8'd0)
        begin
            return 1;
        end
        if (int'(v) > DEF_MAX_SIDE)
        begin
            return DEF_MAX_SIDE;
        end
        return int'(v);
    endfunction

    function automatic int unsigned pick_gap(input bit no_idle);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 50)
        begin
            return 0;
        end
        if (r < 85)
        begin
            return $urandom_range(1, 3);
        end
        if (r < 97)
        begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(20, 40);
    endfunction

    function automatic logic [7:0] pick_side();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 70)
        begin
            return 8'($urandom_range(1, 6));
        end
        if (r < 80)
        begin
            return 8'($urandom_range(7, 16));
        end
        if (r < 87)
        begin
            return 8'(DEF_MAX_SIDE);
        end
        if (r < 92)
        begin
            return 8'd0;
        end
        if (r < 97)
        begin
            return 8'($urandom_range(DEF_MAX_SIDE + 1, 255));
        end
        return 8'd1;
    endfunction

    // A size change after the frame is complete must not expose store entries
    // that were never loaded.
    function automatic bit sizes_safe(input logic [7:0] nw, input logic [7:0] nh);
        return !frame_done || (side_of(nw) * side_of(nh) <= loaded_span);
    endfunction

    task automatic orient_step(input logic req, input logic [PIX_W-1:0] pix,
                               output bit made, output pix_result_t res);
        int unsigned w;
        int unsigned h;
        int unsigned ow;
        int unsigned oh;
        int unsigned sx;
        int unsigned sy;
        bit          swap;
        w    = side_of(cfg_width);
        h    = side_of(cfg_height);
        res  = '0;
        made = 1'b0;
        if (req == REQ_WRITE)
        begin
            if (frame_done)
            begin
                wr_count   = 0;
                rd_x       = 0;
                rd_y       = 0;
                frame_done = 1'b0;
            end
            if (wr_count < STORE_DEPTH)
            begin
                image_copy[wr_count] = pix;
                if (wr_count + 1 > loaded_span)
                begin
                    loaded_span = wr_count + 1;
                end
            end
            wr_count++;
            if (wr_count >= w * h)
            begin
                frame_done = 1'b1;
            end
        end
        else if (!frame_done)
        begin
            made = 1'b1;
            res  = NOT_READY;
        end
        else
        begin
            made = 1'b1;
            swap = (cfg_mode == MODE_ROT90_CW) || (cfg_mode == MODE_ROT90_CCW);
            ow   = swap ? h : w;
            oh   = swap ? w : h;
            if (rd_x >= ow || rd_y >= oh)
            begin
                rd_x = 0;
                rd_y = 0;
            end
            case (cfg_mode)
                MODE_ROT180:
                begin
                    sx = w - 1 - rd_x;
                    sy = h - 1 - rd_y;
                end
                MODE_ROT90_CW:
                begin
                    sx = rd_y;
                    sy = h - 1 - rd_x;
                end
                MODE_ROT90_CCW:
                begin
                    sx = w - 1 - rd_y;
                    sy = rd_x;
                end
                MODE_VFLIP:
                begin
                    sx = rd_x;
                    sy = h - 1 - rd_y;
                end
                MODE_HFLIP:
                begin
                    sx = w - 1 - rd_x;
                    sy = rd_y;
                end
                default:
                begin
                    sx = rd_x;
                    sy = rd_y;
                end
            endcase
            res.pixel  = image_copy[sy * w + sx];
            res.x      = COORD_W'(rd_x);
            res.y      = COORD_W'(rd_y);
            res.last   = (rd_x == ow - 1) && (rd_y == oh - 1);
            res.status = 1'b0;
            if (rd_x + 1 < ow)
            begin
                rd_x = rd_x + 1;
            end
            else
            begin
                rd_x = 0;
                rd_y = (rd_y + 1 < oh) ? rd_y + 1 : 0;
            end
        end
    endtask

    task automatic push_item(input logic req, input logic [PIX_W-1:0] pix,
                             input bit typed, input pix_result_t want);
        int unsigned gap;
        bit          made;
        pix_result_t res;
        gap = pick_gap(burst);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= pix;
        do
        begin
            @(posedge clk);
        end
        while (!s_tready);
        orient_step(req, pix, made, res);
        if (made)
        begin
            pending_pixels.push_back(typed ? want : res);
        end
    endtask

    task automatic random_item(input logic req);
        push_item(req, $urandom(), 1'b0, NO_TYPED);
        items_sent++;
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending_pixels.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] sel, input logic [31:0] val);
        logic [CFG_DATA_W-1:0] read_want;
        wait_idle();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CFG_ADDR_W'({sel, 2'b00});
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (sel)
            REG_MODE:   cfg_mode   = val[2:0];
            REG_WIDTH:  cfg_width  = val[7:0];
            REG_HEIGHT: cfg_height = val[7:0];
            default:    ;
        endcase
        case (sel)
            REG_MODE:   read_want = CFG_DATA_W'(cfg_mode);
            REG_WIDTH:  read_want = CFG_DATA_W'(cfg_width);
            REG_HEIGHT: read_want = CFG_DATA_W'(cfg_height);
            default:    read_want = '0;
        endcase
        @(posedge clk);
        if (prdata !== read_want)
        begin
            fail_cnt++;
            if (fail_cnt <= 10)
            begin
                $display("register readback: expected=%h got=%h", read_want, prdata);
            end
        end
    endtask

    task automatic run_phase(input int unsigned ph);
        logic [7:0]  nw;
        logic [7:0]  nh;
        logic [2:0]  nm;
        int unsigned npull;
        bit          pull_only;
        nm = (ph < 8) ? 3'(ph) : 3'($urandom_range(0, 7));
        nw = pick_side();
        nh = pick_side();
        if (side_of(nw) * side_of(nh) > 512)
        begin
            nh = 8'($urandom_range(1, 2));
        end
        pull_only = frame_done && ($urandom_range(0, 3) == 0);
        write_reg(REG_MODE, 32'(nm));
        if (!pull_only || sizes_safe(nw, nh))
        begin
            write_reg(REG_WIDTH, 32'(nw));
            write_reg(REG_HEIGHT, 32'(nh));
        end
        burst = ($urandom_range(0, 4) == 0);
        if (!pull_only)
        begin
            random_item(REQ_WRITE);
            while (!frame_done)
            begin
                random_item(($urandom_range(0, 99) < 8) ? REQ_PULL : REQ_WRITE);
            end
        end
        npull = $urandom_range(1, 2 * side_of(cfg_width) * side_of(cfg_height) + 1);
        if (npull > 300)
        begin
            npull = 300;
        end
        if (ph % 6 == 1)
        begin
            if (npull < HOLD_PULLS)
            begin
                npull = HOLD_PULLS;
            end
            s_tvalid <= 1'b0;
            hold_req = 1'b1;
            wait (!hold_req);
        end
        repeat (npull)
        begin
            random_item(($urandom_range(0, 99) < 3) ? REQ_WRITE : REQ_PULL);
        end
    endtask

    initial
    begin : sink_pacing
        int unsigned run_len;
        int unsigned gap;
        m_tready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
        begin
            @(posedge clk);
        end
        forever
        begin
            if (hold_req)
            begin
                hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 80)
                                                      : $urandom_range(1, 12);
                m_tready <= 1'b1;
                repeat (run_len) @(posedge clk);
                gap = pick_gap(1'b0);
                if (gap > 0)
                begin
                    m_tready <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
        end
    end

    initial
    begin : result_check
        pix_result_t got;
        pix_result_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready)
            begin
                got.pixel  = m_tdata[31:0];
                got.x      = m_tdata[38:32];
                got.y      = m_tdata[45:39];
                got.last   = m_tlast;
                got.status = m_tuser;
                if (pending_pixels.size() == 0)
                begin
                    fail_cnt++;
                    if (fail_cnt <= 10)
                    begin
                        $display("unexpected result: pixel=%h x=%0d y=%0d last=%b status=%b",
                                 got.pixel, got.x, got.y, got.last, got.status);
                    end
                end
                else
                begin
                    want = pending_pixels.pop_front();
                    if (got.pixel !== want.pixel || got.x !== want.x || got.y !== want.y ||
                        got.last !== want.last || got.status !== want.status)
                    begin
                        fail_cnt++;
                        if (fail_cnt <= 10)
                        begin
                            $display("mismatch: expected pixel=%h x=%0d y=%0d last=%b status=%b",
                                     want.pixel, want.x, want.y, want.last, want.status);
                            $display("          got      pixel=%h x=%0d y=%0d last=%b status=%b",
                                     got.pixel, got.x, got.y, got.last, got.status);
                        end
                    end
                end
            end
        end
    end

    initial
    begin : watchdog
        cycle_cnt = 0;
        while (cycle_cnt < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_cnt++;
        end
        $display("status: fail");
        $finish;
    end

    initial
    begin : stimulus
        int unsigned ph;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= REQ_WRITE;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        rst_n    <= 1'b0;
        wr_count    = 0;
        rd_x        = 0;
        rd_y        = 0;
        loaded_span = 0;
        frame_done  = 1'b0;
        cfg_mode    = MODE_ROT180;
        cfg_width   = SIDE_RESET;
        cfg_height  = SIDE_RESET;
        items_sent  = 0;
        fail_cnt    = 0;
        burst       = 1'b0;
        hold_req    = 1'b0;
        plan = '{
            '{ACT_PULL,  REG_MODE,   32'h0,                 1'b1, NOT_READY},
            '{ACT_REG,   REG_WIDTH,  32'd2,                 1'b0, NO_TYPED},
            '{ACT_REG,   REG_HEIGHT, 32'd2,                 1'b0, NO_TYPED},
            '{ACT_WRITE, REG_MODE,   32'h0000_0000,         1'b0, NO_TYPED},
            '{ACT_WRITE, REG_MODE,   32'hFFFF_FFFF,         1'b0, NO_TYPED},
            '{ACT_PULL,  REG_MODE,   32'hFFFF_FFFF,         1'b1, NOT_READY},
            '{ACT_WRITE, REG_MODE,   32'h8000_0001,         1'b0, NO_TYPED},
            '{ACT_WRITE, REG_MODE,   32'h7FFF_FFFE,         1'b0, NO_TYPED},
            '{ACT_PULL,  REG_MODE,   32'h0,                 1'b0, NO_TYPED},
            '{ACT_PULL,  REG_MODE,   32'h0,                 1'b0, NO_TYPED},
            '{ACT_PULL,  REG_MODE,   32'h0,                 1'b0, NO_TYPED},
            '{ACT_PULL,  REG_MODE,   32'h0,                 1'b0, NO_TYPED},
            '{ACT_PULL,  REG_MODE,   32'h0,                 1'b0, NO_TYPED},
            '{ACT_REG,   REG_MODE,   32'(MODE_ROT90_CW),    1'b0, NO_TYPED},
            '{ACT_PULL,  REG_MODE,   32'h0,                 1'b0, NO_TYPED},
            '{ACT_PULL,  REG_MODE,   32'h0,                 1'b0, NO_TYPED},
            '{ACT_REG,   REG_MODE,   32'(MODE_PASS_TOP),    1'b0, NO_TYPED},
            '{ACT_PULL,  REG_MODE,   32'h0,                 1'b0, NO_TYPED},
            '{ACT_REG,   REG_WIDTH,  32'd0,                 1'b0, NO_TYPED},
            '{ACT_REG,   REG_HEIGHT, 32'd0,                 1'b0, NO_TYPED},
            '{ACT_PULL,  REG_MODE,   32'h0,                 1'b0, NO_TYPED},
            '{ACT_WRITE, REG_MODE,   32'h1234_5678,         1'b0, NO_TYPED},
            '{ACT_PULL,  REG_MODE,   32'h0,                 1'b0, NO_TYPED},
            '{ACT_REG,   REG_MODE,   32'(MODE_ROT180),      1'b0, NO_TYPED},
            '{ACT_PULL,  REG_MODE,   32'h0,                 1'b0, NO_TYPED}
        };
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (plan[i])
        begin
            case (plan[i].kind)
                ACT_REG:   write_reg(plan[i].reg_sel, plan[i].value);
                ACT_WRITE: push_item(REQ_WRITE, plan[i].value, plan[i].typed, plan[i].want);
                default:   push_item(REQ_PULL, plan[i].value, plan[i].typed, plan[i].want);
            endcase
        end
        ph = 0;
        while (items_sent < RANDOM_ITEMS)
        begin
            run_phase(ph);
            ph++;
        end
        wait_idle();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_cnt == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
